### hdl/ddof_pkg.sv
// Package for the differential-drive odometry block.
// Holds the sequencer states, register indexes, heading constants, the
// CORDIC arctangent table, the heading wrap function and a status struct.
package ddof_pkg;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MPC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MPC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_WEIGHT = 3'd4;

    // Heading constants in Q3.16.
    localparam logic signed [22:0] HEAD_PI      = 23'sd205887;
    localparam logic signed [22:0] HEAD_TWO_PI  = 23'sd411775;
    localparam logic signed [22:0] HEAD_HALF_PI = 23'sd102944;
    localparam logic signed [41:0] DTH_LIMIT    = 42'sd524287;

    // CORDIC start value (gain-compensated one in Q.30).
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Speed scale: microseconds per second.
    localparam logic signed [31:0] US_PER_S = 32'sd1000000;

    // Width of the divider dividend (magnitude of a scaled speed).
    localparam int unsigned DIV_W = 44;
    localparam int unsigned PER_W = 20;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_DIFF,
        ST_MUL_TH,
        ST_HEAD,
        ST_MUL_W1,
        ST_MUL_W2,
        ST_BLEND,
        ST_COR1,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_COR2,
        ST_MUL_X1,
        ST_MUL_X2,
        ST_MUL_Y1,
        ST_MUL_Y2,
        ST_MUL_LIN,
        ST_DIV_LIN_S,
        ST_DIV_LIN,
        ST_MUL_ANG,
        ST_DIV_ANG_S,
        ST_DIV_ANG,
        ST_DONE
    } seq_state_t;

    // Status of an iterative unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Arctangent of 2^-i in Q.30.
    function automatic logic signed [35:0] atan_lookup(input logic [4:0] idx);
        logic signed [35:0] v;
        case (idx)
            5'd0:  v = 36'sd843314857;
            5'd1:  v = 36'sd497837830;
            5'd2:  v = 36'sd263043837;
            5'd3:  v = 36'sd133525159;
            5'd4:  v = 36'sd67021687;
            5'd5:  v = 36'sd33543516;
            5'd6:  v = 36'sd16775851;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194283;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048576;
            5'd11: v = 36'sd524288;
            5'd12: v = 36'sd262144;
            5'd13: v = 36'sd131072;
            5'd14: v = 36'sd65536;
            5'd15: v = 36'sd32768;
            5'd16: v = 36'sd16384;
            5'd17: v = 36'sd8192;
            5'd18: v = 36'sd4096;
            5'd19: v = 36'sd2048;
            5'd20: v = 36'sd1024;
            5'd21: v = 36'sd512;
            5'd22: v = 36'sd256;
            5'd23: v = 36'sd128;
            default: v = 36'sd0;
        endcase
        return v;
    endfunction

    // Fold a heading into [-pi, pi]; inputs stay within three periods.
    function automatic logic signed [19:0] wrap_heading(input logic signed [22:0] a);
        logic signed [22:0] v;
        v = a;
        for (int k = 0; k < 3; k++) begin
            if (v > HEAD_PI) begin
                v = v - HEAD_TWO_PI;
            end else if (v < -HEAD_PI) begin
                v = v + HEAD_TWO_PI;
            end
        end
        return v[19:0];
    endfunction

endpackage

### hdl/ddof_cordic.sv
// Iterative CORDIC rotation giving cosine and sine in Q.30.
// Depends on ddof_pkg for the arctangent table and heading wrap.
module ddof_cordic #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [19:0]       angle,
    output logic signed [31:0]       cos_out,
    output logic signed [31:0]       sin_out,
    output ddof_pkg::unit_stat_t     stat
);
    import ddof_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    logic               busy_reg;
    logic               done_reg;
    logic [IW-1:0]      cnt_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [35:0] z_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    logic signed [22:0] ang_fold;
    logic               neg_fold;
    logic signed [33:0] tx;
    logic signed [33:0] ty;
    logic signed [35:0] at;
    logic signed [33:0] x_step;
    logic signed [33:0] y_step;
    logic signed [35:0] z_step;

    // Wrap, then fold the angle into [-pi/2, pi/2] with a sign flip.
    always_comb
    begin
        ang_fold = {{3{1'b0}}, wrap_heading({{3{angle[19]}}, angle})};
        ang_fold = {{3{ang_fold[19]}}, ang_fold[19:0]};
        neg_fold = 1'b0;
        if (ang_fold > HEAD_HALF_PI) begin
            ang_fold = ang_fold - HEAD_PI;
            neg_fold = 1'b1;
        end else if (ang_fold < -HEAD_HALF_PI) begin
            ang_fold = ang_fold + HEAD_PI;
            neg_fold = 1'b1;
        end
    end

    // One micro-rotation of the shared shift-add datapath.
    always_comb
    begin
        tx = y_reg >>> cnt_reg;
        ty = x_reg >>> cnt_reg;
        at = atan_lookup(5'(cnt_reg));
        if (z_reg >= 0) begin
            x_step = x_reg - tx;
            y_step = y_reg + ty;
            z_step = z_reg - at;
        end else begin
            x_step = x_reg + tx;
            y_step = y_reg - ty;
            z_step = z_reg + at;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == IW'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start) begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= 36'(ang_fold) <<< 14;
            neg_reg <= neg_fold;
        end else if (busy_reg) begin
            x_reg <= x_step;
            y_reg <= y_step;
            z_reg <= z_step;
            if (cnt_reg == IW'(CORDIC_STEPS - 1)) begin
                cos_reg <= neg_reg ? -x_step[31:0] : x_step[31:0];
                sin_reg <= neg_reg ? -y_step[31:0] : y_step[31:0];
            end
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hdl/ddof_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ddof_pkg for operand widths and the status struct.
module ddof_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ddof_pkg::DIV_W-1:0]     dividend,
    input  logic [ddof_pkg::PER_W-1:0]     divisor,
    output logic [ddof_pkg::DIV_W-1:0]     quotient,
    output ddof_pkg::unit_stat_t           stat
);
    import ddof_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] q_reg;
    logic [PER_W-1:0] rem_reg;
    logic [PER_W-1:0] den_reg;
    logic [PER_W:0]   rem_s;
    logic             fits;

    // Shift in the next dividend bit and trial-subtract.
    always_comb
    begin
        rem_s = {rem_reg, q_reg[DIV_W-1]};
        fits  = (rem_s >= {1'b0, den_reg});
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient registers.
    always_ff @(posedge clk)
    begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= PER_W'(rem_s - {1'b0, den_reg});
            end else begin
                rem_reg <= rem_s[PER_W-1:0];
            end
            q_reg <= {q_reg[DIV_W-2:0], fits};
        end
    end

    assign quotient = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hdl/diff_drive_odometry_fusion.sv
// Top level of the differential-drive odometry block with heading fusion.
// Depends on ddof_pkg, ddof_cordic and ddof_divider.
//
//  channel   direction  handshake          payload
//  in        sink       in_valid/in_ready  left_count right_count period_us imu_heading
//  out       source     out_valid/out_ready x/y_position heading speeds stationary updated
//  cfg       sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// An item with a nonzero period runs both CORDIC rotations and the two 44-bit
// divisions of the speeds, which take most of its time; an item with a zero
// period goes straight to ST_DONE. One item is in work at a time.
// Reset clears the pose, both headings and the registers to their defaults.
// A stalled result holds in the output registers; the next result waits in ST_DONE.
module diff_drive_odometry_fusion #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ddof_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddof_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [15:0]                left_count,
    input  logic signed [15:0]                right_count,
    input  logic [19:0]                       period_us,
    input  logic signed [18:0]                imu_heading,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                x_position,
    output logic signed [31:0]                y_position,
    output logic signed [18:0]                heading,
    output logic signed [31:0]                linear_speed,
    output logic signed [31:0]                angular_speed,
    output logic                              stationary,
    output logic                              updated
);
    import ddof_pkg::*;

    // Configuration registers.
    logic [23:0] left_mpc_reg;
    logic [23:0] right_mpc_reg;
    logic [23:0] inv_track_reg;
    logic        imu_mode_reg;
    logic [16:0] imu_weight_reg;

    // Sequencer and working registers.
    seq_state_t         state_reg, state_next;
    logic signed [15:0] lc_reg, rc_reg;
    logic [19:0]        period_reg;
    logic signed [18:0] imu_reg;
    logic signed [40:0] dl_reg, dl_next;
    logic signed [24:0] dxy_reg, dxy_next;
    logic signed [33:0] t_reg, t_next;
    logic signed [19:0] dth_reg, dth_next;
    logic signed [21:0] wh_reg, wh_next;
    logic signed [19:0] dimu_reg, dimu_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [65:0] prod_reg;
    logic signed [33:0] dx_reg, dx_next;
    logic signed [33:0] dy_reg, dy_next;
    logic               neg_reg, neg_next;

    // Architectural state.
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [19:0] fused_reg, fused_next;
    logic signed [19:0] wheel_reg, wheel_next;
    logic signed [19:0] prev_reg, prev_next;
    logic               pend_reg, pend_next;
    logic signed [31:0] lin_reg, lin_next;
    logic signed [31:0] ang_reg, ang_next;
    logic               stat_reg;
    logic               upd_reg;

    // Output registers.
    logic               out_valid_reg, out_valid_next;
    logic               load_out;
    logic signed [31:0] x_out_reg, y_out_reg, lin_out_reg, ang_out_reg;
    logic signed [18:0] head_out_reg;
    logic               stat_out_reg, upd_out_reg;

    // Shared multiplier.
    logic               mul_en;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;

    // Iterative units.
    logic               cor_start;
    logic signed [19:0] cor_angle;
    logic signed [31:0] cor_cos, cor_sin;
    unit_stat_t         cor_stat;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_quot;
    unit_stat_t         div_stat;

    // Temporaries of the sequencer.
    logic               in_xfer;
    logic signed [41:0] sum_lr;
    logic signed [41:0] dif_lr;
    logic signed [41:0] th_full;
    logic signed [17:0] w_clip;
    logic signed [66:0] acc_sum;
    logic signed [36:0] acc_rnd;
    logic signed [65:0] prod_abs;

    // Saturate a rounded position step onto a 32-bit position.
    function automatic logic signed [31:0] pos_add(input logic signed [31:0] p,
                                                   input logic signed [66:0] s);
        logic signed [36:0] r;
        logic signed [37:0] t;
        r = 37'((s + 67'sd536870912) >>> 30);
        t = 38'(p) + 38'(r);
        if (t > 38'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (t < -38'sd2147483648) begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    // Apply the sign to a quotient magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] quot_sat(input logic [DIV_W-1:0] q,
                                                    input logic neg);
        if (neg) begin
            if (q > DIV_W'(64'd2147483648)) begin
                return 32'sh80000000;
            end
            return -q[31:0];
        end
        if (q > DIV_W'(64'd2147483647)) begin
            return 32'sh7FFFFFFF;
        end
        return q[31:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign w_clip    = (imu_weight_reg > 17'd65536) ? 18'sd65536
                                                    : $signed({1'b0, imu_weight_reg});

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_mpc_reg   <= 24'd917901;
            right_mpc_reg  <= 24'd915700;
            inv_track_reg  <= 24'd209649;
            imu_mode_reg   <= 1'b1;
            imu_weight_reg <= 17'd64225;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LEFT_MPC:   left_mpc_reg   <= cfg_data;
                REG_RIGHT_MPC:  right_mpc_reg  <= cfg_data;
                REG_INV_TRACK:  inv_track_reg  <= cfg_data;
                REG_IMU_MODE:   imu_mode_reg   <= cfg_data[0];
                REG_IMU_WEIGHT: imu_weight_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_L:   begin mul_a = 34'(lc_reg); mul_b = $signed({8'd0, left_mpc_reg}); end
            ST_MUL_R:   begin mul_a = 34'(rc_reg); mul_b = $signed({8'd0, right_mpc_reg}); end
            ST_MUL_TH:  begin mul_a = t_reg; mul_b = $signed({8'd0, inv_track_reg}); end
            ST_MUL_W1:  begin mul_a = 34'(w_clip); mul_b = 32'(fused_reg) + 32'(dimu_reg); end
            ST_MUL_W2:  begin mul_a = 34'sd65536 - 34'(w_clip); mul_b = 32'(wh_reg); end
            ST_MUL_DX:  begin mul_a = 34'(dxy_reg); mul_b = cor_cos; end
            ST_MUL_DY:  begin mul_a = 34'(dxy_reg); mul_b = cor_sin; end
            ST_MUL_X1:  begin mul_a = dx_reg; mul_b = cor_cos; end
            ST_MUL_X2:  begin mul_a = dy_reg; mul_b = cor_sin; end
            ST_MUL_Y1:  begin mul_a = dx_reg; mul_b = cor_sin; end
            ST_MUL_Y2:  begin mul_a = dy_reg; mul_b = cor_cos; end
            ST_MUL_LIN: begin mul_a = 34'(dxy_reg); mul_b = US_PER_S; end
            ST_MUL_ANG: begin mul_a = 34'(dth_reg); mul_b = US_PER_S; end
            default:    mul_en = 1'b0;
        endcase
    end

    // Product register after the multiplier.
    always_ff @(posedge clk)
    begin
        if (mul_en) begin
            prod_reg <= 66'(mul_a) * 66'(mul_b);
        end
    end

    // Next state and datapath of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        dl_next        = dl_reg;
        dxy_next       = dxy_reg;
        t_next         = t_reg;
        dth_next       = dth_reg;
        wh_next        = wh_reg;
        dimu_next      = dimu_reg;
        acc_next       = acc_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        neg_next       = neg_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        fused_next     = fused_reg;
        wheel_next     = wheel_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        lin_next       = lin_reg;
        ang_next       = ang_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;
        cor_start      = 1'b0;
        cor_angle      = dth_reg;
        div_start      = 1'b0;
        sum_lr         = 42'(dl_reg) + 42'($signed(prod_reg[40:0]));
        dif_lr         = 42'($signed(prod_reg[40:0])) - 42'(dl_reg);
        th_full        = 42'((prod_reg + 66'sd8388608) >>> 24);
        acc_sum        = 67'(acc_reg) + 67'(prod_reg);
        acc_rnd        = 37'((acc_sum + 67'sd32768) >>> 16);
        prod_abs       = prod_reg[65] ? -prod_reg : prod_reg;
        div_dividend   = prod_abs[DIV_W-1:0];

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    lin_next = '0;
                    ang_next = '0;
                    state_next = (period_us == '0) ? ST_DONE : ST_MUL_L;
                end
            end
            ST_MUL_L:   state_next = ST_MUL_R;
            ST_MUL_R:
            begin
                dl_next = prod_reg[40:0];
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dxy_next = 25'((sum_lr + 42'sd65536) >>> 17);
                t_next   = 34'((dif_lr + 42'sd128) >>> 8);
                state_next = ST_MUL_TH;
            end
            ST_MUL_TH:  state_next = ST_HEAD;
            ST_HEAD:
            begin
                // Saturated heading change, encoder heading and IMU change.
                if (th_full > DTH_LIMIT) begin
                    dth_next = 20'sd524287;
                end else if (th_full < -DTH_LIMIT) begin
                    dth_next = -20'sd524287;
                end else begin
                    dth_next = th_full[19:0];
                end
                wh_next = 22'(wheel_reg) + 22'(dth_next);
                if (imu_mode_reg) begin
                    if (dth_next != '0) begin
                        pend_next = 1'b1;
                    end else if (pend_reg) begin
                        pend_next = 1'b0;
                        wh_next = 22'(fused_reg);
                    end
                end
                dimu_next = wrap_heading(23'(imu_reg) - 23'(prev_reg));
                state_next = ST_MUL_W1;
            end
            ST_MUL_W1:  state_next = ST_MUL_W2;
            ST_MUL_W2:
            begin
                acc_next = prod_reg;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                // Complementary blend in IMU mode, wraps, then rotate by the heading change.
                if (imu_mode_reg) begin
                    fused_next = wrap_heading(acc_rnd[22:0]);
                end else begin
                    fused_next = wrap_heading(23'(wh_reg));
                end
                wheel_next = wrap_heading(23'(wh_reg));
                prev_next  = 20'(imu_reg);
                cor_start  = 1'b1;
                cor_angle  = dth_reg;
                state_next = ST_COR1;
            end
            ST_COR1:
            begin
                if (cor_stat.done) begin
                    state_next = ST_MUL_DX;
                end
            end
            ST_MUL_DX:  state_next = ST_MUL_DY;
            ST_MUL_DY:
            begin
                dx_next = 34'((prod_reg + 66'sd536870912) >>> 30);
                cor_start = 1'b1;
                cor_angle = fused_reg;
                state_next = ST_COR2;
            end
            ST_COR2:
            begin
                if (cor_stat.done) begin
                    dy_next = 34'((prod_reg + 66'sd536870912) >>> 30);
                    state_next = ST_MUL_X1;
                end
            end
            ST_MUL_X1:  state_next = ST_MUL_X2;
            ST_MUL_X2:
            begin
                acc_next = prod_reg;
                state_next = ST_MUL_Y1;
            end
            ST_MUL_Y1:
            begin
                pos_x_next = pos_add(pos_x_reg, 67'(acc_reg) - 67'(prod_reg));
                state_next = ST_MUL_Y2;
            end
            ST_MUL_Y2:
            begin
                acc_next = prod_reg;
                state_next = ST_MUL_LIN;
            end
            ST_MUL_LIN:
            begin
                pos_y_next = pos_add(pos_y_reg, acc_sum);
                state_next = ST_DIV_LIN_S;
            end
            ST_DIV_LIN_S:
            begin
                neg_next = prod_reg[65];
                div_start = 1'b1;
                state_next = ST_DIV_LIN;
            end
            ST_DIV_LIN:
            begin
                if (div_stat.done) begin
                    lin_next = quot_sat(div_quot, neg_reg);
                    state_next = ST_MUL_ANG;
                end
            end
            ST_MUL_ANG: state_next = ST_DIV_ANG_S;
            ST_DIV_ANG_S:
            begin
                neg_next = prod_reg[65];
                div_start = 1'b1;
                state_next = ST_DIV_ANG;
            end
            ST_DIV_ANG:
            begin
                if (div_stat.done) begin
                    ang_next = quot_sat(div_quot, neg_reg);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hand the result to the output registers once they are free.
                if (!out_valid_reg || out_ready) begin
                    load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer, pose and output control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            fused_reg     <= '0;
            wheel_reg     <= '0;
            prev_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            fused_reg     <= fused_next;
            wheel_reg     <= wheel_next;
            prev_reg      <= prev_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and the input capture.
    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            lc_reg     <= left_count;
            rc_reg     <= right_count;
            period_reg <= period_us;
            imu_reg    <= imu_heading;
            stat_reg   <= (left_count == '0) && (right_count == '0);
            upd_reg    <= (period_us != '0);
        end
        dl_reg   <= dl_next;
        dxy_reg  <= dxy_next;
        t_reg    <= t_next;
        dth_reg  <= dth_next;
        wh_reg   <= wh_next;
        dimu_reg <= dimu_next;
        acc_reg  <= acc_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        neg_reg  <= neg_next;
        lin_reg  <= lin_next;
        ang_reg  <= ang_next;
        if (load_out) begin
            x_out_reg    <= pos_x_reg;
            y_out_reg    <= pos_y_reg;
            head_out_reg <= fused_reg[18:0];
            lin_out_reg  <= lin_reg;
            ang_out_reg  <= ang_reg;
            stat_out_reg <= stat_reg;
            upd_out_reg  <= upd_reg;
        end
    end

    ddof_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .cos_out (cor_cos),
        .sin_out (cor_sin),
        .stat    (cor_stat)
    );

    ddof_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    assign out_valid     = out_valid_reg;
    assign x_position    = x_out_reg;
    assign y_position    = y_out_reg;
    assign heading       = head_out_reg;
    assign linear_speed  = lin_out_reg;
    assign angular_speed = ang_out_reg;
    assign stationary    = stat_out_reg;
    assign updated       = upd_out_reg;

    // The CORDIC unit is started only when it is free.
    a_cor_free: assert property (@(posedge clk) disable iff (!rst_n)
        cor_start |-> !cor_stat.busy)
        else $error("CORDIC started while busy");

    // The divider is started only when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A transfer with a zero period goes straight to the result.
    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && period_us == '0) |=> (state_reg == ST_DONE))
        else $error("zero period did not skip the update");

    // A result is loaded only when the output register is free or being drained.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending transfer");

endmodule

### bench/tb_diff_drive_odometry_fusion.sv
// Self-checking testbench for the differential-drive odometry block with heading fusion.
// Depends on ddof_pkg and the diff_drive_odometry_fusion RTL; a built-in pose predictor
// checks every result against the expected pose, heading, speeds and flags.
`timescale 1ns / 100ps

module tb_diff_drive_odometry_fusion;
    import ddof_pkg::*;

    localparam int STEPS = 18;
    localparam int IDLE_LIMIT = 5000;
    localparam longint Q_PI = 205887;
    localparam longint Q_TWO_PI = 411775;
    localparam longint Q_HALF_PI = 102944;
    localparam longint TURN_LIMIT = 524287;
    localparam longint UNITY_GAIN = 652032874;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [19:0] period;
        logic signed [18:0] imu;
    } odo_sample_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [18:0] head;
        logic signed [31:0] lin;
        logic signed [31:0] ang;
        logic stat;
        logic upd;
    } pose_report_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic [19:0] period_us;
    logic signed [18:0] imu_heading;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic signed [18:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic stationary;
    logic updated;

    // Predictor state and register copies.
    longint pose_x, pose_y, fused_yaw, wheel_yaw, last_imu;
    bit resync_armed;
    longint mpc_left, mpc_right, inv_track, fuse_on, fuse_weight;

    pose_report_t pending_poses[$];
    int error_count = 0;
    int idle_cycles = 0;
    int rx_hold_cycles;
    bit rx_no_stall;
    bit tx_no_gap;
    longint imu_track;

    diff_drive_odometry_fusion #(.CORDIC_STEPS(STEPS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .left_count(left_count), .right_count(right_count),
        .period_us(period_us), .imu_heading(imu_heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .x_position(x_position), .y_position(y_position), .heading(heading),
        .linear_speed(linear_speed), .angular_speed(angular_speed),
        .stationary(stationary), .updated(updated)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Fixed-point helpers: floor shift with half-up rounding, clamp, heading fold.
    function automatic longint round_shift(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint fold_yaw(input longint v);
        longint a;
        a = v;
        while (a > Q_PI)
            a -= Q_TWO_PI;
        while (a < -Q_PI)
            a += Q_TWO_PI;
        return a;
    endfunction

    // Rotation-mode CORDIC in Q.30 after folding the angle into the right half plane.
    function automatic void sincos_q30(input longint angle, output longint c, output longint s);
        longint a, xr, yr, zr, tx, ty;
        bit flip;
        a = fold_yaw(angle);
        flip = 1'b0;
        if (a > Q_HALF_PI)
        begin
            a -= Q_PI;
            flip = 1'b1;
        end
        else if (a < -Q_HALF_PI)
        begin
            a += Q_PI;
            flip = 1'b1;
        end
        xr = UNITY_GAIN;
        yr = 0;
        zr = a * 16384;
        for (int i = 0; i < STEPS; i++)
        begin
            tx = yr >>> i;
            ty = xr >>> i;
            if (zr >= 0)
            begin
                xr -= tx;
                yr += ty;
                zr -= longint'(atan_lookup(i[4:0]));
            end
            else
            begin
                xr += tx;
                yr -= ty;
                zr += longint'(atan_lookup(i[4:0]));
            end
        end
        c = flip ? -xr : xr;
        s = flip ? -yr : yr;
    endfunction

    // Advance the predicted pose by one sample and return the expected report.
    function automatic pose_report_t advance_pose(input odo_sample_t smp);
        pose_report_t r;
        longint lc, rc, dl, dr, travel, turn, dimu, w, c1, s1, c2, s2, dx, dy;
        longint lin, ang;
        lc = smp.left;
        rc = smp.right;
        lin = 0;
        ang = 0;
        if (smp.period != 0)
        begin
            dl = lc * mpc_left;
            dr = rc * mpc_right;
            travel = round_shift(dl + dr, 17);
            turn = round_shift(round_shift(dr - dl, 8) * inv_track, 24);
            turn = clamp(turn, -TURN_LIMIT, TURN_LIMIT);
            wheel_yaw += turn;
            dimu = fold_yaw(longint'(smp.imu) - last_imu);
            if (fuse_on != 0)
            begin
                // Resync the encoder heading once turning stops.
                if (turn != 0)
                    resync_armed = 1'b1;
                else if (resync_armed)
                begin
                    resync_armed = 1'b0;
                    wheel_yaw = fused_yaw;
                end
                w = (fuse_weight > 65536) ? 65536 : fuse_weight;
                fused_yaw = round_shift(w * (fused_yaw + dimu) + (65536 - w) * wheel_yaw, 16);
            end
            else
            begin
                fused_yaw = wheel_yaw;
            end
            wheel_yaw = fold_yaw(wheel_yaw);
            fused_yaw = fold_yaw(fused_yaw);
            last_imu = smp.imu;
            sincos_q30(turn, c1, s1);
            dx = round_shift(travel * c1, 30);
            dy = round_shift(travel * s1, 30);
            sincos_q30(fused_yaw, c2, s2);
            pose_x = clamp(pose_x + round_shift(c2 * dx - s2 * dy, 30), S32_MIN, S32_MAX);
            pose_y = clamp(pose_y + round_shift(s2 * dx + c2 * dy, 30), S32_MIN, S32_MAX);
            lin = clamp(travel * 1000000 / longint'(smp.period), S32_MIN, S32_MAX);
            ang = clamp(turn * 1000000 / longint'(smp.period), S32_MIN, S32_MAX);
        end
        r.x = pose_x[31:0];
        r.y = pose_y[31:0];
        r.head = fused_yaw[18:0];
        r.lin = lin[31:0];
        r.ang = ang[31:0];
        r.stat = (lc == 0) && (rc == 0);
        r.upd = (smp.period != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Random gap length: mostly none or short, now and then long.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // Send one sample over the input channel and record its expected report.
    task automatic send_sample(input odo_sample_t smp);
        int gap;
        gap = tx_no_gap ? 0 : random_gap();
        repeat (gap) @(negedge clk);
        left_count = smp.left;
        right_count = smp.right;
        period_us = smp.period;
        imu_heading = smp.imu;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_poses.push_back(advance_pose(smp));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input longint value);
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LEFT_MPC:   mpc_left = value & 64'hFFFFFF;
            REG_RIGHT_MPC:  mpc_right = value & 64'hFFFFFF;
            REG_INV_TRACK:  inv_track = value & 64'hFFFFFF;
            REG_IMU_MODE:   fuse_on = value & 64'h1;
            REG_IMU_WEIGHT: fuse_weight = value & 64'h1FFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every expected report has come back, then let the block settle.
    task automatic wait_drained();
        while (pending_poses.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_config(input longint l, input longint r, input longint inv,
                              input longint mode, input longint w);
        wait_drained();
        write_register(REG_LEFT_MPC, l);
        write_register(REG_RIGHT_MPC, r);
        write_register(REG_INV_TRACK, inv);
        write_register(REG_IMU_MODE, mode);
        write_register(REG_IMU_WEIGHT, w);
    endtask

    function automatic odo_sample_t make_sample(input int lc, input int rc, input int per,
                                                input longint imu);
        odo_sample_t s;
        s.left = 16'(lc);
        s.right = 16'(rc);
        s.period = 20'(per);
        s.imu = imu[18:0];
        return s;
    endfunction

    // Realistic period, with occasional zero, tiny or full-range values.
    function automatic int pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 50);
        if (r < 13)
            return $urandom_range(0, 20'hFFFFF);
        return $urandom_range(10000, 100000);
    endfunction

    // IMU heading that drifts slowly, wrapping, with rare full-range jumps.
    function automatic longint next_imu(input int drift);
        if ($urandom_range(0, 49) == 0)
        begin
            imu_track = $signed(19'($urandom));
            return imu_track;
        end
        imu_track = fold_yaw(imu_track + drift + $signed($urandom_range(0, 400)) - 200);
        return imu_track;
    endfunction

    function automatic int small_count(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // One stretch of motion: straight runs, turns ending in a stop, standing still, or noise.
    task automatic drive_segment();
        int kind, len, base, turn_rate;
        kind = $urandom_range(0, 9);
        len = $urandom_range(2, 12);
        base = small_count(300);
        turn_rate = small_count(80);
        for (int k = 0; k < len; k++)
        begin
            case (kind)
                0, 1, 2:
                    send_sample(make_sample(base + small_count(3), base + small_count(3),
                                            pick_period(), next_imu(0)));
                3, 4, 5:
                    send_sample(make_sample(base - turn_rate, base + turn_rate,
                                            pick_period(), next_imu(turn_rate * 40)));
                6:
                    send_sample(make_sample(0, 0, pick_period(), next_imu(0)));
                7:
                    send_sample(make_sample(small_count(32767), small_count(32767),
                                            pick_period(), next_imu(0)));
                default:
                    send_sample(make_sample($urandom, $urandom, $urandom_range(0, 20'hFFFFF),
                                            $signed(19'($urandom))));
            endcase
        end
        // Stop after turning so the encoder heading resyncs.
        if (kind >= 3 && kind <= 5)
            send_sample(make_sample(0, 0, pick_period(), next_imu(0)));
    endtask

    // Extremes of every field, zero period, IMU wrap; default, maximum, zero settings.
    task automatic test_directed_cases();
        send_sample(make_sample(0, 0, 0, 0));
        send_sample(make_sample(100, 100, 0, 1000));
        send_sample(make_sample(0, 0, 50000, 0));
        send_sample(make_sample(32767, 32767, 1, 0));
        send_sample(make_sample(-32768, -32768, 1, 0));
        send_sample(make_sample(-32768, 32767, 20000, 205887));
        send_sample(make_sample(0, 0, 20000, -205887));
        send_sample(make_sample(32767, -32768, 1000000, 205000));
        send_sample(make_sample(10, 10, 20'hFFFFF, -205000));
        send_sample(make_sample(0, 0, 30000, 262143));
        send_sample(make_sample(500, 600, 30000, -262144));
        send_sample(make_sample(0, 0, 30000, 0));
        send_sample(make_sample(-1, 1, 30000, 100));
        send_sample(make_sample(1, -1, 30000, 100));
        send_sample(make_sample(0, 0, 30000, 100));
        set_config(16777215, 16777215, 16777215, 1, 131071);
        send_sample(make_sample(-32768, 32767, 100, 0));
        send_sample(make_sample(32767, -32768, 100, 1));
        send_sample(make_sample(0, 0, 100, 2));
        set_config(0, 0, 0, 0, 0);
        send_sample(make_sample(32767, -32768, 100, 205887));
        send_sample(make_sample(0, 0, 100, 0));
        wait_drained();
        write_register(3'd7, 24'hFFFFFF);
    endtask

    // Random motion under a range of register settings, extremes included.
    task automatic test_random_drive(input longint l, input longint r, input longint inv,
                                     input longint mode, input longint w, input int count);
        int start;
        set_config(l, r, inv, mode, w);
        start = 0;
        while (start < count)
        begin
            drive_segment();
            start += 8;
        end
    endtask

    // Long straight full-speed drive to push the position into saturation.
    task automatic test_position_saturation();
        set_config(16777215, 16777215, 1, 0, 0);
        tx_no_gap = 1'b1;
        rx_no_stall = 1'b1;
        for (int k = 0; k < 300; k++)
            send_sample(make_sample(32767, 32767, 20000, 0));
        for (int k = 0; k < 20; k++)
            send_sample(make_sample(-32768, -32768, 20000, 0));
        tx_no_gap = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    // Receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_backpressure();
        set_config(917901, 915700, 209649, 1, 64225);
        rx_hold_cycles = 600;
        for (int k = 0; k < 12; k++)
            send_sample(make_sample(small_count(500), small_count(500), 20000, next_imu(300)));
    endtask

    // Sender pauses until every report is back, then resumes.
    task automatic test_sender_drain();
        for (int k = 0; k < 20; k++)
        begin
            send_sample(make_sample(small_count(200), small_count(200), pick_period(), next_imu(0)));
            if (k % 5 == 4)
                wait_drained();
        end
    endtask

    // Receiver ready: random stalls, forced hold-off, or always ready.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_ready = 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_no_stall)
                out_ready = 1'b1;
            else if (out_ready)
                out_ready = ($urandom_range(0, 99) >= 25);
            else
                out_ready = (random_gap() == 0);
        end
    end

    // Compare each accepted report with the oldest expectation.
    always @(posedge clk)
    begin
        pose_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $display("[%0t] report with nothing expected", $time);
                error_count++;
            end
            else
            begin
                want = pending_poses.pop_front();
                if (x_position !== want.x)
                    report_mismatch("x_position", x_position, want.x);
                if (y_position !== want.y)
                    report_mismatch("y_position", y_position, want.y);
                if (heading !== want.head)
                    report_mismatch("heading", heading, want.head);
                if (linear_speed !== want.lin)
                    report_mismatch("linear_speed", linear_speed, want.lin);
                if (angular_speed !== want.ang)
                    report_mismatch("angular_speed", angular_speed, want.ang);
                if (stationary !== want.stat)
                    report_mismatch("stationary", stationary, want.stat);
                if (updated !== want.upd)
                    report_mismatch("updated", updated, want.upd);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        left_count = '0;
        right_count = '0;
        period_us = '0;
        imu_heading = '0;
        rx_hold_cycles = 0;
        rx_no_stall = 1'b0;
        tx_no_gap = 1'b0;
        imu_track = 0;
        pose_x = 0;
        pose_y = 0;
        fused_yaw = 0;
        wheel_yaw = 0;
        last_imu = 0;
        resync_armed = 1'b0;
        mpc_left = 917901;
        mpc_right = 915700;
        inv_track = 209649;
        fuse_on = 1;
        fuse_weight = 64225;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_drive(917901, 915700, 209649, 1, 64225, 300);
        test_random_drive(917901, 915700, 209649, 0, 64225, 200);
        test_random_drive(16777215, 16777215, 16777215, 1, 65536, 150);
        test_random_drive(0, 0, 1, 1, 0, 100);
        test_random_drive($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                          $urandom_range(0, 24'hFFFFFF), 1, $urandom_range(0, 17'h1FFFF), 250);
        test_random_drive(1000000, 1000000, 0, 1, 131071, 100);
        test_position_saturation();
        test_output_backpressure();
        test_sender_drain();
        test_random_drive(900000, 930000, 400000, 1, 32768, 200);

        wait_drained();
        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
